@@ sv/rbs_pkg.sv @@
// Shared types and constants for the record buffer splitter.
package rbs_pkg;

   // Buffer and record layout.
   localparam int BUFFER_BYTES_DEF = 1024;
   localparam int KEY_BYTES        = 8;
   localparam int LEN_BYTES        = 2;
   localparam int HDR_BYTES        = KEY_BYTES + LEN_BYTES;
   localparam int KEY_W            = 8 * KEY_BYTES;
   localparam int LEN_W            = 8 * LEN_BYTES;
   localparam int HDR_W            = 8 * HDR_BYTES;
   localparam int CNT_W            = 4;
   localparam int VLEN_W           = LEN_W - 1;
   localparam int PLEN_W           = 6;
   localparam int CMD_DEPTH        = 4;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_PREFIX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LEN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPACT_MODE = 2'd2;

   typedef enum logic [1:0] {
      PHASE_KEY,
      PHASE_LEN,
      PHASE_VAL
   } phase_type;

   typedef enum logic [1:0] {
      ROUTE_DROP,
      ROUTE_LOWER,
      ROUTE_UPPER
   } route_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_write_type;

   // One command from the parser to the emitter.
   typedef struct packed {
      logic [CNT_W-1:0] nbytes;   // bytes to copy: 0, 1 or a whole header
      logic             side;     // 0 lower, 1 upper
      logic             eob;      // end of buffer: a summary follows
      logic             trunc;    // buffer ended inside a record
      logic [HDR_W-1:0] payload;  // header bytes, first byte in the low bits
   } cmd_type;

endpackage

@@ sv/rbs_if.sv @@
// Channel interfaces for the node buffer input and the result output.
interface rbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface rbs_rsp_if #(
   parameter int OFF_W = 10
);
   logic             valid;
   logic             ready;
   logic [7:0]       out_byte;
   logic             side;
   logic             record_start;
   logic [OFF_W-1:0] write_offset;
   logic             is_summary;
   logic [OFF_W:0]   lower_size;
   logic [OFF_W:0]   upper_size;
   logic             truncated;
   logic             last_of_run;

   modport source (
      output valid, output out_byte, output side, output record_start,
      output write_offset, output is_summary, output lower_size,
      output upper_size, output truncated, output last_of_run, input ready
   );
   modport sink (
      input valid, input out_byte, input side, input record_start,
      input write_offset, input is_summary, input lower_size,
      input upper_size, input truncated, input last_of_run, output ready
   );
endinterface

@@ sv/rbs_front.sv @@
// Parser front end: holds configuration, parses records and issues commands.
module rbs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  rbs_pkg::csr_write_type csr,
   rbs_req_if.sink               req,
   input  logic                  fifo_full,
   output logic                  push,
   output rbs_pkg::cmd_type      push_cmd
);

   logic [rbs_pkg::KEY_W-1:0]  prefix_ff;
   logic [rbs_pkg::PLEN_W-1:0] plen_ff;
   logic                       compact_ff;

   rbs_pkg::phase_type         phase_ff, phase_in, phase_data;
   rbs_pkg::route_type         route_ff, route_in, route_new;
   logic [rbs_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [rbs_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [rbs_pkg::LEN_W-1:0]  len_ff, len_in, len_full;
   logic [rbs_pkg::VLEN_W-1:0] remain_ff, remain_in, vlen;

   logic                       take;
   logic                       hdr_done;
   logic [rbs_pkg::PLEN_W-1:0] bit_pos;
   logic [rbs_pkg::KEY_W-1:0]  pivot_bit;
   logic [rbs_pkg::KEY_W-1:0]  pivot;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff  <= '0;
         plen_ff    <= '0;
         compact_ff <= 1'b0;
      end else if (csr.we) begin
         case (csr.index)
            rbs_pkg::CSR_SPLIT_PREFIX: prefix_ff  <= csr.wdata;
            rbs_pkg::CSR_PREFIX_LEN:   plen_ff    <= csr.wdata[rbs_pkg::PLEN_W-1:0];
            rbs_pkg::CSR_COMPACT_MODE: compact_ff <= csr.wdata[0];
            default: ;
         endcase
      end
   end

   assign req.ready = !fifo_full;
   assign take      = req.valid && !fifo_full;

   // Pivot: keep the prefix bits above the pivot bit and set the pivot bit.
   assign bit_pos   = rbs_pkg::PLEN_W'(63) - plen_ff;
   assign pivot_bit = rbs_pkg::KEY_W'(1) << bit_pos;
   assign pivot     = (prefix_ff & ~(pivot_bit - rbs_pkg::KEY_W'(1))) | pivot_bit;

   assign len_full  = {req.data_byte, len_ff[rbs_pkg::LEN_W-1:8]};
   assign vlen      = len_full[rbs_pkg::VLEN_W-1:0];
   assign hdr_done  = cnt_ff == rbs_pkg::CNT_W'(rbs_pkg::HDR_BYTES - 1);

   // Route of a record whose header is complete.
   always_comb begin
      if (len_full[rbs_pkg::VLEN_W]) begin
         route_new = rbs_pkg::ROUTE_DROP;
      end else if (compact_ff || (key_ff < pivot)) begin
         route_new = rbs_pkg::ROUTE_LOWER;
      end else begin
         route_new = rbs_pkg::ROUTE_UPPER;
      end
   end

   // Next parse phase, before and after the end of buffer is applied.
   always_comb begin
      phase_data = phase_ff;
      case (phase_ff)
         rbs_pkg::PHASE_KEY: begin
            if (cnt_ff == rbs_pkg::CNT_W'(rbs_pkg::KEY_BYTES - 1)) begin
               phase_data = rbs_pkg::PHASE_LEN;
            end
         end
         rbs_pkg::PHASE_LEN: begin
            if (hdr_done) begin
               phase_data = (vlen == '0) ? rbs_pkg::PHASE_KEY : rbs_pkg::PHASE_VAL;
            end
         end
         rbs_pkg::PHASE_VAL: begin
            if (remain_ff == rbs_pkg::VLEN_W'(1)) begin
               phase_data = rbs_pkg::PHASE_KEY;
            end
         end
         default: phase_data = rbs_pkg::PHASE_KEY;
      endcase
      phase_in = phase_ff;
      if (take) begin
         phase_in = req.end_of_buffer ? rbs_pkg::PHASE_KEY : phase_data;
      end
   end

   // Datapath updates and the command for the emitter.
   always_comb begin
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      route_in  = route_ff;
      push_cmd  = '0;
      push_cmd.side  = route_ff == rbs_pkg::ROUTE_UPPER;
      push_cmd.eob   = req.end_of_buffer;
      // A record is open unless this byte closed it; a key byte always leaves one open.
      push_cmd.trunc = (phase_data != rbs_pkg::PHASE_KEY) || (phase_ff == rbs_pkg::PHASE_KEY);
      if (take) begin
         case (phase_ff)
            rbs_pkg::PHASE_KEY: begin
               key_in = {req.data_byte, key_ff[rbs_pkg::KEY_W-1:8]};
               cnt_in = cnt_ff + rbs_pkg::CNT_W'(1);
            end
            rbs_pkg::PHASE_LEN: begin
               len_in = len_full;
               cnt_in = cnt_ff + rbs_pkg::CNT_W'(1);
               if (hdr_done) begin
                  route_in  = route_new;
                  remain_in = vlen;
                  push_cmd.side    = route_new == rbs_pkg::ROUTE_UPPER;
                  push_cmd.payload = {len_full, key_ff};
                  if (route_new != rbs_pkg::ROUTE_DROP) begin
                     push_cmd.nbytes = rbs_pkg::CNT_W'(rbs_pkg::HDR_BYTES);
                  end
               end
            end
            rbs_pkg::PHASE_VAL: begin
               remain_in = remain_ff - rbs_pkg::VLEN_W'(1);
               push_cmd.payload = rbs_pkg::HDR_W'(req.data_byte);
               if (route_ff != rbs_pkg::ROUTE_DROP) begin
                  push_cmd.nbytes = rbs_pkg::CNT_W'(1);
               end
            end
            default: ;
         endcase
         // Back at a record boundary: clear the parse state.
         if (phase_in == rbs_pkg::PHASE_KEY && phase_ff != rbs_pkg::PHASE_KEY) begin
            cnt_in    = '0;
            route_in  = rbs_pkg::ROUTE_DROP;
            remain_in = '0;
         end
         if (req.end_of_buffer) begin
            cnt_in    = '0;
            route_in  = rbs_pkg::ROUTE_DROP;
            remain_in = '0;
         end
      end
      push = take && ((push_cmd.nbytes != '0) || req.end_of_buffer);
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rbs_pkg::PHASE_KEY;
         route_ff  <= rbs_pkg::ROUTE_DROP;
         cnt_ff    <= '0;
         remain_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         route_ff  <= route_in;
         cnt_ff    <= cnt_in;
         remain_ff <= remain_in;
      end
   end

   // Header bytes are shifted in; a full header overwrites every bit.
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      len_ff <= len_in;
   end

endmodule

@@ sv/rbs_cmd_fifo.sv @@
// Short command queue between the parser and the emitter.
module rbs_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbs_pkg::cmd_type push_cmd,
   input  logic             pop,
   output rbs_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(rbs_pkg::CMD_DEPTH);

   rbs_pkg::cmd_type   mem_ff [rbs_pkg::CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff, count_in;

   assign empty = count_ff == '0;
   assign full  = count_ff == (PTR_W + 1)'(rbs_pkg::CMD_DEPTH);
   assign head  = mem_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // The parser never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("command queue overflow");
   // The emitter never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("command queue underflow");
   // Occupancy tracks the pointers.
   assert property (@(posedge clock) disable iff (reset)
      full |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");

endmodule

@@ sv/rbs_back.sv @@
// Emitter: expands commands into output transactions and keeps both fills.
module rbs_back #(
   parameter int BUFFER_BYTES = rbs_pkg::BUFFER_BYTES_DEF,
   parameter int OFF_W        = $clog2(BUFFER_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  rbs_pkg::cmd_type head,
   input  logic             fifo_empty,
   output logic             pop,
   rbs_rsp_if.source        rsp
);

   localparam int SIZE_W = OFF_W + 1;

   logic [rbs_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [SIZE_W-1:0]         lower_ff, lower_in;
   logic [SIZE_W-1:0]         upper_ff, upper_in;

   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff, out_byte_in;
   logic                      out_side_ff, out_side_in;
   logic                      out_start_ff, out_start_in;
   logic [OFF_W-1:0]          out_off_ff, out_off_in;
   logic                      out_summ_ff, out_summ_in;
   logic [SIZE_W-1:0]         out_lsize_ff, out_lsize_in;
   logic [SIZE_W-1:0]         out_usize_ff, out_usize_in;
   logic                      out_trunc_ff, out_trunc_in;
   logic                      out_last_ff, out_last_in;

   logic [SIZE_W-1:0]         fill;
   logic                      slot_free;
   logic                      adv;
   logic                      side_full;
   logic                      side_near;
   logic                      last_idx;
   logic                      data_act;
   logic                      emit;

   assign fill      = head.side ? upper_ff : lower_ff;
   assign side_full = fill >= SIZE_W'(BUFFER_BYTES);
   assign side_near = fill == SIZE_W'(BUFFER_BYTES - 1);
   assign last_idx  = idx_ff == (head.nbytes - rbs_pkg::CNT_W'(1));
   assign data_act  = (idx_ff < head.nbytes) && !side_full;
   assign slot_free = !out_valid_ff || rsp.ready;
   assign adv       = !fifo_empty && slot_free;

   // One output transaction per cycle, while the output slot is free, from the command at the queue head.
   always_comb begin
      idx_in       = idx_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      out_byte_in  = '0;
      out_side_in  = 1'b0;
      out_start_in = 1'b0;
      out_off_in   = '0;
      out_summ_in  = 1'b0;
      out_lsize_in = '0;
      out_usize_in = '0;
      out_trunc_in = 1'b0;
      out_last_in  = 1'b0;
      if (adv) begin
         if (data_act) begin
            // Copy one byte to its side; a filled side stops taking bytes.
            emit         = 1'b1;
            out_byte_in  = head.payload[{idx_ff, 3'b000} +: 8];
            out_side_in  = head.side;
            out_start_in = (head.nbytes == rbs_pkg::CNT_W'(rbs_pkg::HDR_BYTES))
                           && (idx_ff == '0);
            out_off_in   = fill[OFF_W-1:0];
            out_last_in  = !head.eob && (last_idx || side_near);
            if (head.side) begin
               upper_in = upper_ff + SIZE_W'(1);
            end else begin
               lower_in = lower_ff + SIZE_W'(1);
            end
            if ((last_idx || side_near) && !head.eob) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + rbs_pkg::CNT_W'(1);
            end
         end else if (head.eob) begin
            // End of buffer: report both sizes and start a new buffer.
            emit         = 1'b1;
            out_summ_in  = 1'b1;
            out_lsize_in = lower_ff;
            out_usize_in = upper_ff;
            out_trunc_in = head.trunc;
            out_last_in  = 1'b1;
            lower_in     = '0;
            upper_in     = '0;
            pop          = 1'b1;
            idx_in       = '0;
         end else begin
            pop    = 1'b1;
            idx_in = '0;
         end
      end
      out_valid_in = slot_free ? emit : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         lower_ff     <= '0;
         upper_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output register: loads only when the slot is free and a command waits.
   always_ff @(posedge clock) begin
      if (adv) begin
         out_byte_ff  <= out_byte_in;
         out_side_ff  <= out_side_in;
         out_start_ff <= out_start_in;
         out_off_ff   <= out_off_in;
         out_summ_ff  <= out_summ_in;
         out_lsize_ff <= out_lsize_in;
         out_usize_ff <= out_usize_in;
         out_trunc_ff <= out_trunc_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_byte     = out_byte_ff;
   assign rsp.side         = out_side_ff;
   assign rsp.record_start = out_start_ff;
   assign rsp.write_offset = out_off_ff;
   assign rsp.is_summary   = out_summ_ff;
   assign rsp.lower_size   = out_lsize_ff;
   assign rsp.upper_size   = out_usize_ff;
   assign rsp.truncated    = out_trunc_ff;
   assign rsp.last_of_run  = out_last_ff;

   // Fills saturate at the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      (lower_ff <= SIZE_W'(BUFFER_BYTES)) && (upper_ff <= SIZE_W'(BUFFER_BYTES)))
      else $error("side fill beyond buffer size");
   // The byte index never runs past a header.
   assert property (@(posedge clock) disable iff (reset)
      idx_ff <= rbs_pkg::CNT_W'(rbs_pkg::HDR_BYTES))
      else $error("byte index out of range");
   // A summary always closes its run and clears both fills.
   assert property (@(posedge clock) disable iff (reset)
      (adv && !data_act && head.eob) |=> (out_valid_ff && out_summ_ff && out_last_ff
      && (lower_ff == '0) && (upper_ff == '0)))
      else $error("summary transaction malformed");

endmodule

@@ sv/record_buffer_splitter.sv @@
// Top level of the record buffer splitter.
//
//   channel    direction  handshake              payload
//   req_chan   in         valid/ready            data_byte, end_of_buffer
//   rsp_chan   out        valid/ready            byte, side, offset, summary fields
//   csr_*      in         csr_we, no wait        csr_index, csr_wdata
//
// The parser takes a buffer byte whenever the command queue is not full. A live
// record's header leaves the emitter as ten transactions, one per cycle, and each
// value byte as one, while the receiver is ready; an end-of-buffer summary is one
// more transaction. A four-entry command queue lets the parser run ahead while a
// header drains, so input stalls only when that queue is full. Reset is synchronous
// and clears the parse state, both fills, the queue and the output valid at once.
module record_buffer_splitter #(
   parameter int BUFFER_BYTES = rbs_pkg::BUFFER_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   rbs_req_if.sink                          req_chan,
   rbs_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [rbs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rbs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int OFF_W = $clog2(BUFFER_BYTES);

   rbs_pkg::csr_write_type csr;
   rbs_pkg::cmd_type       push_cmd;
   rbs_pkg::cmd_type       head;
   logic                   push;
   logic                   pop;
   logic                   fifo_empty;
   logic                   fifo_full;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // Parser.
   rbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req       (req_chan),
      .fifo_full (fifo_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Command queue.
   rbs_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (fifo_empty),
      .full     (fifo_full)
   );

   // Emitter.
   rbs_back #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .OFF_W        (OFF_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the record buffer splitter: directed and random node buffers.
module tb;

   localparam int BUF_BYTES     = 1024;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 50;

   // One result as the block should present it.
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        side;
      logic        record_start;
      logic [9:0]  write_offset;
      logic        is_summary;
      logic [10:0] lower_size;
      logic [10:0] upper_size;
      logic        truncated;
      logic        last_of_run;
   } split_result_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_QUARTER,
      RDY_MOSTLY
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic                           csr_we;
   logic [rbs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rbs_pkg::CSR_DATA_W-1:0] csr_wdata;

   rbs_req_if req_if ();
   rbs_rsp_if #(.OFF_W(10)) rsp_if ();

   record_buffer_splitter #(.BUFFER_BYTES(BUF_BYTES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies seen by the splitter model.
   logic [63:0] cfg_prefix;
   logic [5:0]  cfg_plen;
   logic        cfg_compact;

   // Parser and fill state of the splitter model.
   rbs_pkg::phase_type parse_phase;
   rbs_pkg::route_type cur_route;
   int                 hdr_cnt;
   logic [63:0]        key_acc;
   logic [15:0]        len_acc;
   logic [14:0]        val_left;
   logic [10:0]        lower_fill;
   logic [10:0]        upper_fill;
   int                 run_len;

   split_result_type routed_q[$];
   logic [7:0]       rec_bytes[$];
   split_result_type seen_r;
   split_result_type want_r;
   int               fail_count = 0;
   int               burst_left = 0;
   int               stall_tick = 0;
   stall_mode_type   stall_mode = RDY_ALWAYS;

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pivot of the split: upper prefix bits kept, pivot bit set.
   function automatic logic [63:0] split_pivot();
      logic [63:0] pivot_bit;
      pivot_bit = 64'd1 << (63 - cfg_plen);
      return (cfg_prefix & ~(pivot_bit - 64'd1)) | pivot_bit;
   endfunction

   function automatic void clear_parse();
      parse_phase = rbs_pkg::PHASE_KEY;
      hdr_cnt     = 0;
      key_acc     = '0;
      len_acc     = '0;
      val_left    = '0;
      cur_route   = rbs_pkg::ROUTE_DROP;
   endfunction

   // Append one copied byte to the expected results, unless its record is dropped or its side is full.
   function automatic void place_byte(input logic [7:0] b, input logic first);
      split_result_type r;
      r = '0;
      if (cur_route == rbs_pkg::ROUTE_LOWER && lower_fill < BUF_BYTES) begin
         r.write_offset = lower_fill[9:0];
         lower_fill++;
      end else if (cur_route == rbs_pkg::ROUTE_UPPER && upper_fill < BUF_BYTES) begin
         r.side         = 1'b1;
         r.write_offset = upper_fill[9:0];
         upper_fill++;
      end else begin
         return;
      end
      r.out_byte     = b;
      r.record_start = first;
      routed_q.push_back(r);
      run_len++;
   endfunction

   // Work out every result that one accepted buffer byte causes.
   function automatic void split_byte(input logic [7:0] b, input logic eob);
      split_result_type r;
      logic [14:0]      vlen;
      int               i;
      run_len = 0;
      if (parse_phase == rbs_pkg::PHASE_KEY) begin
         key_acc = key_acc | (64'(b) << (hdr_cnt * 8));
         hdr_cnt++;
         if (hdr_cnt >= rbs_pkg::KEY_BYTES) parse_phase = rbs_pkg::PHASE_LEN;
      end else if (parse_phase == rbs_pkg::PHASE_LEN) begin
         len_acc = len_acc | (16'(b) << ((hdr_cnt - rbs_pkg::KEY_BYTES) * 8));
         hdr_cnt++;
         if (hdr_cnt >= rbs_pkg::HDR_BYTES) begin
            vlen = len_acc[14:0];
            if (len_acc[15]) begin
               cur_route = rbs_pkg::ROUTE_DROP;
            end else if (cfg_compact || key_acc < split_pivot()) begin
               cur_route = rbs_pkg::ROUTE_LOWER;
            end else begin
               cur_route = rbs_pkg::ROUTE_UPPER;
            end
            if (cur_route != rbs_pkg::ROUTE_DROP) begin
               for (i = 0; i < rbs_pkg::KEY_BYTES; i++) begin
                  place_byte(key_acc[i*8 +: 8], i == 0);
               end
               for (i = 0; i < rbs_pkg::LEN_BYTES; i++) begin
                  place_byte(len_acc[i*8 +: 8], 1'b0);
               end
            end
            val_left = vlen;
            if (vlen == 0) begin
               clear_parse();
            end else begin
               parse_phase = rbs_pkg::PHASE_VAL;
            end
         end
      end else begin
         place_byte(b, 1'b0);
         if (val_left > 0) val_left--;
         if (val_left == 0) clear_parse();
      end

      // The summary closes the buffer and resets both fills.
      if (eob) begin
         r            = '0;
         r.is_summary = 1'b1;
         r.lower_size = lower_fill;
         r.upper_size = upper_fill;
         r.truncated  = (parse_phase != rbs_pkg::PHASE_KEY) || (hdr_cnt != 0);
         routed_q.push_back(r);
         run_len++;
         clear_parse();
         lower_fill = '0;
         upper_fill = '0;
      end
      if (run_len > 0) routed_q[routed_q.size() - 1].last_of_run = 1'b1;
   endfunction

   // Send one buffer byte, then maybe open a gap in the burst.
   task automatic send_byte(input logic [7:0] b, input logic eob);
      int gap;
      @(negedge clock);
      req_if.valid         = 1'b1;
      req_if.data_byte     = b;
      req_if.end_of_buffer = eob;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      split_byte(b, eob);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(0, 20);
      end
   endtask

   // Send the collected bytes; the last one carries the end flag if asked.
   task automatic send_buffer(input logic close);
      int n;
      int i;
      n = rec_bytes.size();
      for (i = 0; i < n; i++) send_byte(rec_bytes[i], close && (i == n - 1));
      rec_bytes.delete();
   endtask

   // Hold the input until every expected result has come and the block settles.
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (routed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rbs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == rbs_pkg::CSR_SPLIT_PREFIX) begin
         cfg_prefix = value;
      end else if (idx == rbs_pkg::CSR_PREFIX_LEN) begin
         cfg_plen = value[5:0];
      end else if (idx == rbs_pkg::CSR_COMPACT_MODE) begin
         cfg_compact = value[0];
      end
   endtask

   task automatic set_config(input logic [63:0] prefix, input logic [5:0] plen,
                             input logic compact);
      drain();
      csr_write(rbs_pkg::CSR_SPLIT_PREFIX, prefix);
      csr_write(rbs_pkg::CSR_PREFIX_LEN, 64'(plen));
      csr_write(rbs_pkg::CSR_COMPACT_MODE, 64'(compact));
   endtask

   task automatic add_header(input logic [63:0] key, input logic [15:0] len_word);
      int i;
      for (i = 0; i < rbs_pkg::KEY_BYTES; i++) rec_bytes.push_back(key[i*8 +: 8]);
      rec_bytes.push_back(len_word[7:0]);
      rec_bytes.push_back(len_word[15:8]);
   endtask

   task automatic add_values(input int n);
      repeat (n) rec_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_record(input logic [63:0] key, input logic [15:0] len_word);
      add_header(key, len_word);
      add_values(int'(len_word[14:0]));
   endtask

   // Keys near the pivot, at the extremes, or anywhere.
   function automatic logic [63:0] pick_key();
      case ($urandom_range(0, 5))
         0: begin
            return split_pivot();
         end
         1: begin
            return split_pivot() - 64'd1;
         end
         2: begin
            return 64'd0;
         end
         3: begin
            return '1;
         end
         4: begin
            return split_pivot() ^ 64'($urandom_range(0, 255));
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   // Two full records, a lone key byte and a first length byte with the end flag.
   task automatic test_header_bytes();
      add_record(64'd0, 16'd2);
      add_record('1, 16'd1);
      send_buffer(1'b1);
      rec_bytes.push_back(8'hFF);
      send_buffer(1'b1);
      add_header(64'h0123_4567_89AB_CDEF, 16'h0004);
      void'(rec_bytes.pop_back());
      send_buffer(1'b1);
   endtask

   // Zero-length values, deleted records and length bytes at their extremes.
   task automatic test_zero_and_deleted();
      add_record(64'h8000_0000_0000_0000, 16'h0000);
      add_record(64'h7FFF_FFFF_FFFF_FFFF, 16'h8003);
      add_record(64'h0000_0000_0000_0001, 16'h00FF);
      add_record(64'hFFFF_FFFF_0000_0000, 16'h0000);
      send_buffer(1'b1);
      add_record(64'h5555_AAAA_5555_AAAA, 16'h8000);
      add_header(64'hAAAA_5555_AAAA_5555, 16'hFFFF);
      add_values(2);
      send_buffer(1'b1);
   endtask

   // Pivot at both ends of the prefix length and the prefix value.
   task automatic test_pivot_extremes();
      logic [63:0] prefixes[4];
      logic [5:0]  plens[4];
      int          i;
      prefixes = '{64'd0, '1, {$urandom, $urandom}, 64'h0123_4567_89AB_CDEF};
      plens    = '{6'd0, 6'd63, 6'd31, 6'd17};
      for (i = 0; i < 4; i++) begin
         set_config(prefixes[i], plens[i], 1'b0);
         add_record(split_pivot() - 64'd1, 16'($urandom_range(0, 3)));
         add_record(split_pivot(), 16'($urandom_range(0, 3)));
         add_record(64'd0, 16'd1);
         add_record('1, 16'd1);
         send_buffer(1'b1);
      end
   endtask

   // Compact mode sends every live record to the lower side.
   task automatic test_compact();
      set_config(64'd0, 6'd0, 1'b1);
      add_record('1, 16'd3);
      add_record(64'd0, 16'd0);
      add_record(64'h8000_0000_0000_0000, 16'h8001);
      add_record(64'hC000_0000_0000_0000, 16'd2);
      send_buffer(1'b1);
   endtask

   // A side that fills up stops taking bytes and its size saturates.
   task automatic test_overflow();
      set_config(64'd0, 6'd0, 1'b1);
      add_record(64'd0, 16'd1100);
      add_record(64'd1, 16'd4);
      send_buffer(1'b1);
      set_config(64'd0, 6'd0, 1'b0);
      add_record(64'd2, 16'd3);
      add_record('1, 16'd1020);
      add_record(64'hF000_0000_0000_0000, 16'd5);
      send_buffer(1'b1);
   endtask

   // Registers changed between the two length bytes steer the record.
   task automatic test_mid_record_config();
      logic [7:0] held;
      set_config(64'd0, 6'd0, 1'b0);
      add_header('1, 16'h0003);
      held = rec_bytes.pop_back();
      send_buffer(1'b0);
      set_config(64'd0, 6'd0, 1'b1);
      rec_bytes.push_back(held);
      add_values(3);
      send_buffer(1'b1);
      set_config('1, 6'd63, 1'b0);
      add_header(64'd0, 16'h0002);
      held = rec_bytes.pop_back();
      send_buffer(1'b0);
      set_config(64'd0, 6'd0, 1'b0);
      rec_bytes.push_back(held);
      add_values(2);
      send_buffer(1'b1);
   endtask

   // Mostly well-formed buffers with random content, some cut short, some noise.
   task automatic test_random_buffers();
      int          live_bytes;
      int          cut;
      logic [15:0] len_word;
      live_bytes = 0;
      while (live_bytes < 150) begin
         if ($urandom_range(0, 3) == 0) begin
            set_config({$urandom, $urandom}, 6'($urandom_range(0, 63)),
                       $urandom_range(0, 4) == 0);
         end
         if ($urandom_range(0, 6) == 0) begin
            add_values($urandom_range(1, 24));
            send_buffer(1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 4) == 0) begin
                  len_word = 16'h8000 | 16'($urandom_range(0, 6));
               end else begin
                  len_word = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(16, 40))
                                                         : 16'($urandom_range(0, 6));
                  live_bytes += rbs_pkg::HDR_BYTES + int'(len_word);
               end
               add_record(pick_key(), len_word);
            end
            if ($urandom_range(0, 4) == 0) begin
               cut = $urandom_range(1, rec_bytes.size());
               while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
            end
            send_buffer(1'b1);
         end
      end
   endtask

   // Receiver readiness follows a stall mode that changes now and then.
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 97 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         RDY_ALWAYS: begin
            rsp_if.ready = 1'b1;
         end
         RDY_COIN: begin
            rsp_if.ready = 1'($urandom_range(0, 1));
         end
         RDY_QUARTER: begin
            rsp_if.ready = (stall_tick % 4 == 0);
         end
         default: begin
            rsp_if.ready = ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         seen_r.out_byte     = rsp_if.out_byte;
         seen_r.side         = rsp_if.side;
         seen_r.record_start = rsp_if.record_start;
         seen_r.write_offset = rsp_if.write_offset;
         seen_r.is_summary   = rsp_if.is_summary;
         seen_r.lower_size   = rsp_if.lower_size;
         seen_r.upper_size   = rsp_if.upper_size;
         seen_r.truncated    = rsp_if.truncated;
         seen_r.last_of_run  = rsp_if.last_of_run;
         if (routed_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, seen_r);
            fail_count++;
         end else begin
            want_r = routed_q.pop_front();
            check_field("out_byte", 64'(want_r.out_byte), 64'(seen_r.out_byte));
            check_field("side", 64'(want_r.side), 64'(seen_r.side));
            check_field("record_start", 64'(want_r.record_start), 64'(seen_r.record_start));
            check_field("write_offset", 64'(want_r.write_offset), 64'(seen_r.write_offset));
            check_field("is_summary", 64'(want_r.is_summary), 64'(seen_r.is_summary));
            check_field("lower_size", 64'(want_r.lower_size), 64'(seen_r.lower_size));
            check_field("upper_size", 64'(want_r.upper_size), 64'(seen_r.upper_size));
            check_field("truncated", 64'(want_r.truncated), 64'(seen_r.truncated));
            check_field("last_of_run", 64'(want_r.last_of_run), 64'(seen_r.last_of_run));
         end
      end
   end

   // Stop a run that hangs.
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Reset, the tests in turn, then the final verdict.
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.data_byte     = '0;
      req_if.end_of_buffer = 1'b0;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      cfg_prefix           = '0;
      cfg_plen             = '0;
      cfg_compact          = 1'b0;
      lower_fill           = '0;
      upper_fill           = '0;
      clear_parse();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_header_bytes();
      test_zero_and_deleted();
      test_pivot_extremes();
      test_compact();
      test_overflow();
      test_mid_record_config();
      test_random_buffers();

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (routed_q.size() != 0) begin
         $display("%0t: results missing: expected %0d more, actual 0", $time, routed_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/rbs_pkg.sv
sv/rbs_if.sv
sv/rbs_front.sv
sv/rbs_cmd_fifo.sv
sv/rbs_back.sv
sv/record_buffer_splitter.sv
bench/tb.sv
